>>> hdl/signed_int_to_decimal_ascii_defines.svh
// Assertion macros for the checker file of the decimal text converter.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SITDA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("sitda assertion failed");

// Next-cycle implication, checked outside reset.
`define SITDA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sitda assertion failed");

`endif

>>> hdl/sitda_pkg.sv
// Shared types and constants of the signed integer to decimal text converter.
// Depends on nothing.
package sitda_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int CHAR_WIDTH  = 8;
    localparam int BCD_WIDTH   = 4;

    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'd57;

    // Smallest digit that must be corrected before a doubling step.
    localparam logic [BCD_WIDTH-1:0] BCD_ADJUST_MIN = 4'd5;
    localparam logic [BCD_WIDTH-1:0] BCD_ADJUST     = 4'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

endpackage

>>> hdl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text. An item is taken only while the block is idle and
// then occupies it until its last character enters the output stage: one accept step,
// VALUE_BITS double-dabble steps through the row of digit cells (one magnitude bit a
// cycle), then the row shifts toward the top cell once per digit position, skipping
// leading zeros and emitting the rest, with the sign, if any, emitted before the first
// digit. Characters leave through a registered output stage. No request is taken while
// reset is asserted.
// Depends on sitda_pkg and sitda_digit_cell.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] i_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [sitda_pkg::CHAR_WIDTH-1:0] o_character,
    output logic                            o_last
);

    // Decimal digits needed for a magnitude below 2**VALUE_BITS.
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int BW         = sitda_pkg::BCD_WIDTH;

    sitda_pkg::t_state   r_state, n_state;
    sitda_pkg::t_cell_op w_op;

    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_idx, n_idx;

    logic                              r_o_valid, n_o_valid;
    logic [sitda_pkg::CHAR_WIDTH-1:0]  r_o_char, n_o_char;
    logic                              r_o_last, n_o_last;

    logic [VALUE_BITS-1:0] w_raw;
    logic                  w_slot;
    logic                  w_top_zero;
    logic [BW-1:0]         w_digit [NUM_DIGITS];
    logic [NUM_DIGITS-2:0] w_carry;

    assign w_raw      = i_value[VALUE_BITS-1:0];
    assign w_slot     = !r_o_valid || i_ready;
    assign w_top_zero = (w_digit[NUM_DIGITS-1] == '0);

    // Digit row: cell 0 is least significant, the top cell feeds the output.
    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        logic          w_in_bit;
        logic [BW-1:0] w_in_digit;
        if (i == 0) begin : g_first
            assign w_in_bit   = r_mag[VALUE_BITS-1];
            assign w_in_digit = '0;
        end else begin : g_rest
            assign w_in_bit   = w_carry[i-1];
            assign w_in_digit = w_digit[i-1];
        end
        if (i == NUM_DIGITS-1) begin : g_top
            sitda_digit_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_bit   (w_in_bit),
                .i_digit (w_in_digit),
                .o_bit   (),
                .o_digit (w_digit[i])
            );
        end else begin : g_mid
            sitda_digit_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op),
                .i_bit   (w_in_bit),
                .i_digit (w_in_digit),
                .o_bit   (w_carry[i]),
                .o_digit (w_digit[i])
            );
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_o_valid = r_o_valid && !i_ready;
        n_o_char  = r_o_char;
        n_o_last  = r_o_last;
        w_op      = sitda_pkg::CELL_HOLD;
        o_ready   = 1'b0;
        case (r_state)
            sitda_pkg::ST_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid) begin
                    n_neg   = w_raw[VALUE_BITS-1];
                    // The most negative value keeps its full magnitude as unsigned.
                    n_mag   = w_raw[VALUE_BITS-1] ? (~w_raw + 1'b1) : w_raw;
                    n_cnt   = CNT_W'(VALUE_BITS - 1);
                    w_op    = sitda_pkg::CELL_CLEAR;
                    n_state = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV: begin
                w_op  = sitda_pkg::CELL_DABBLE;
                n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_idx   = IDX_W'(NUM_DIGITS - 1);
                    n_state = sitda_pkg::ST_SKIP;
                end
            end
            sitda_pkg::ST_SKIP: begin
                if (w_top_zero && (r_idx != '0)) begin
                    w_op  = sitda_pkg::CELL_SHIFT;
                    n_idx = r_idx - 1'b1;
                end else if (!r_neg) begin
                    n_state = sitda_pkg::ST_EMIT;
                end else if (w_slot) begin
                    n_o_valid = 1'b1;
                    n_o_char  = sitda_pkg::CHAR_MINUS;
                    n_o_last  = 1'b0;
                    n_state   = sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_EMIT: begin
                if (w_slot) begin
                    w_op      = sitda_pkg::CELL_SHIFT;
                    n_o_valid = 1'b1;
                    n_o_char  = sitda_pkg::CHAR_ZERO +
                                {{(sitda_pkg::CHAR_WIDTH-BW){1'b0}}, w_digit[NUM_DIGITS-1]};
                    n_o_last  = (r_idx == '0);
                    n_idx     = r_idx - 1'b1;
                    if (r_idx == '0) begin
                        n_state = sitda_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sitda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sitda_pkg::ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
    end

    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;

endmodule

>>> hdl/sitda_digit_cell.sv
// One decimal digit of the conversion chain: double-dabble step or digit shift.
// Depends on sitda_pkg.
module sitda_digit_cell (
    input  logic                          i_clk,
    input  sitda_pkg::t_cell_op           i_op,
    input  logic                          i_bit,
    input  logic [sitda_pkg::BCD_WIDTH-1:0] i_digit,
    output logic                          o_bit,
    output logic [sitda_pkg::BCD_WIDTH-1:0] o_digit
);

    logic [sitda_pkg::BCD_WIDTH-1:0] r_digit;
    logic [sitda_pkg::BCD_WIDTH-1:0] n_digit;
    logic [sitda_pkg::BCD_WIDTH-1:0] w_adj;

    // Add three to digits of five or more so the doubling carries in decimal.
    assign w_adj = (r_digit >= sitda_pkg::BCD_ADJUST_MIN) ?
                   (r_digit + sitda_pkg::BCD_ADJUST) : r_digit;

    always_comb begin
        case (i_op)
            sitda_pkg::CELL_CLEAR:  n_digit = '0;
            sitda_pkg::CELL_DABBLE: n_digit = {w_adj[sitda_pkg::BCD_WIDTH-2:0], i_bit};
            sitda_pkg::CELL_SHIFT:  n_digit = i_digit;
            default:                n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_bit   = w_adj[sitda_pkg::BCD_WIDTH-1];
    assign o_digit = r_digit;

endmodule

>>> hdl/sitda_checker.sv
// Port-level checks for the signed integer to decimal text converter, bound to the top.
// Depends on sitda_pkg and signed_int_to_decimal_ascii_defines.svh.
`include "signed_int_to_decimal_ascii_defines.svh"

module sitda_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [sitda_pkg::CHAR_WIDTH-1:0] o_character,
    input logic                             o_last
);

    logic w_is_minus;
    logic w_is_digit;

    assign w_is_minus = (o_character == sitda_pkg::CHAR_MINUS);
    assign w_is_digit = (o_character >= sitda_pkg::CHAR_ZERO) &&
                        (o_character <= sitda_pkg::CHAR_NINE);

    // A stalled character holds until it is taken.
    `SITDA_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable({o_character, o_last}))

    // Only a minus sign or a decimal digit leaves the block.
    `SITDA_ASSERT_NOW(a_char_range, o_valid, w_is_minus || w_is_digit)

    // The sign is always followed by at least one digit.
    `SITDA_ASSERT_NOW(a_minus_not_last, o_valid && w_is_minus, !o_last)

    // No new request is taken while a number's text is still being produced.
    `SITDA_ASSERT_NOW(a_busy_mid_run, o_valid && !o_last, !o_ready)

    // After a request is taken the block is busy converting.
    `SITDA_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);
